// ===== rtl/stack_permutation_checker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Stack permutation checker assertion macros
// Shared helpers for the concurrent checks of the checker's top level.
// ----------------------------------------------------------------------------
`ifndef STACK_PERMUTATION_CHECKER_TOP_DEFINES_SVH
`define STACK_PERMUTATION_CHECKER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack permutation checker package
// Field widths, register map and parameter defaults.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int COACH_W         = 11;
    localparam int NEXT_W          = COACH_W + 1;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int MAX_COACHES_DEF = 1024;

    // Register index decoded from paddr[2].
    localparam logic REG_TRAIN_LENGTH = 1'b0;

endpackage

// ===== rtl/spc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stack_permutation_checker_top.sv =====
// Steps: each accepted coach is evaluated; a lost train goes straight to the finish step, a coach
// on top of the stack is compared first, and otherwise coaches are pushed until the wanted one comes.
// The finish step registers the verdict after the last coach of a train. A new coach is taken only
// once the last one is through. A verdict still held stalls the last item.
// Reset (synchronous, active low) empties the stack, clears the counters and sets
// train_length to 1; the stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Stack permutation checker
// Checks whether a wanted coach order can be produced through one stack.
// ----------------------------------------------------------------------------
`include "stack_permutation_checker_top_defines.svh"

module stack_permutation_checker_top #(
    parameter int MAX_COACHES = spc_pkg::MAX_COACHES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [spc_pkg::COACH_W-1:0] i_coach,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_achievable,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spc_pkg::PADDR_W-1:0] paddr,
    input  logic [spc_pkg::PDATA_W-1:0] pwdata,
    output logic [spc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW = (MAX_COACHES > 1) ? $clog2(MAX_COACHES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH,
        S_CMP,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [spc_pkg::COACH_W-1:0] r_train_length;
    logic [spc_pkg::COACH_W-1:0] r_coach;
    logic [spc_pkg::COACH_W-1:0] r_depth;
    logic [spc_pkg::NEXT_W-1:0]  r_next;
    logic [spc_pkg::COACH_W-1:0] r_items;
    logic                        r_failed;
    logic                        r_out_valid;
    logic                        r_achievable;

    logic [spc_pkg::COACH_W-1:0] len;
    logic [spc_pkg::NEXT_W-1:0]  coach_ext;
    logic [spc_pkg::NEXT_W-1:0]  items_inc;
    logic                        cfg_write;
    logic                        out_free;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [spc_pkg::COACH_W-1:0] ram_rdata;

    always_comb begin
        len = r_train_length;
        if (r_train_length == '0) begin
            len = spc_pkg::COACH_W'(1);
        end else if (int'(r_train_length) > MAX_COACHES) begin
            len = spc_pkg::COACH_W'(MAX_COACHES);
        end
    end

    assign coach_ext = {1'b0, r_coach};
    assign items_inc = {1'b0, r_items} + spc_pkg::NEXT_W'(1);
    assign cfg_write = psel && penable && pwrite && (paddr[2] == spc_pkg::REG_TRAIN_LENGTH);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Coaches below the wanted one go onto the stack; the wanted one is popped at once.
    assign ram_we    = (r_state == S_PUSH) && (r_next < coach_ext);
    assign ram_waddr = AW'(r_depth);
    assign ram_raddr = AW'(r_depth - spc_pkg::COACH_W'(1));

    spc_ram #(
        .WIDTH (spc_pkg::COACH_W),
        .DEPTH (MAX_COACHES),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_next[spc_pkg::COACH_W-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_train_length <= spc_pkg::COACH_W'(1);
            r_depth        <= '0;
            r_next         <= spc_pkg::NEXT_W'(1);
            r_items        <= '0;
            r_failed       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_coach <= i_coach;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_failed || r_coach == '0 || r_coach > len) begin
                        r_failed <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (r_next <= coach_ext) begin
                        r_state <= S_PUSH;
                    end else if (r_depth == '0) begin
                        r_failed <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_PUSH: begin
                    r_next <= r_next + spc_pkg::NEXT_W'(1);
                    if (r_next < coach_ext) begin
                        r_depth <= r_depth + spc_pkg::COACH_W'(1);
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CMP: begin
                    if (ram_rdata == r_coach) begin
                        r_depth <= r_depth - spc_pkg::COACH_W'(1);
                    end else begin
                        r_failed <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (items_inc >= {1'b0, len}) begin
                        // Last item of the sequence: hold until the output register frees.
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_achievable <= !r_failed;
                            r_depth      <= '0;
                            r_next       <= spc_pkg::NEXT_W'(1);
                            r_items      <= '0;
                            r_failed     <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_items <= items_inc[spc_pkg::COACH_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Writing the length starts a new sequence.
            if (cfg_write) begin
                r_train_length <= pwdata[spc_pkg::COACH_W-1:0];
                r_depth        <= '0;
                r_next         <= spc_pkg::NEXT_W'(1);
                r_items        <= '0;
                r_failed       <= 1'b0;
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_achievable = r_achievable;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == spc_pkg::REG_TRAIN_LENGTH)
                        ? spc_pkg::PDATA_W'(r_train_length) : '0;

    `SPC_ASSERT_NOW(a_depth_below_next, 1'b1, {1'b0, r_depth} < r_next, "depth overran")
    `SPC_ASSERT_NOW(a_push_not_failed, r_state == S_PUSH, !r_failed, "push on failed train")
    `SPC_ASSERT_NOW(a_cmp_nonempty, r_state == S_CMP, r_depth != '0, "compare on empty stack")
    `SPC_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE,
        "result outside finish step")
    `SPC_ASSERT_NEXT(a_accept_evaluates, (r_state == S_IDLE) && i_in_valid,
        r_state == S_EVAL, "accepted coach not evaluated")

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Stack permutation checker testbench
// Feeds wanted coach orders through the item channel, predicts the verdict of
// every completed train in step with each accepted transfer, and compares it
// with the result channel while both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STACK_DEPTH = spc_pkg::MAX_COACHES_DEF;
    localparam logic [spc_pkg::PADDR_W-1:0] TRAIN_LENGTH_ADDR =
        {spc_pkg::REG_TRAIN_LENGTH, 2'b00};
    localparam logic [spc_pkg::PADDR_W-1:0] SPARE_ADDR =
        {~spc_pkg::REG_TRAIN_LENGTH, 2'b00};
    localparam int RANDOM_COACHES = 900;
    localparam int QUIET_COACHES  = 100;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic [spc_pkg::COACH_W-1:0] i_coach      = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic                        o_achievable;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [spc_pkg::PADDR_W-1:0] paddr        = '0;
    logic [spc_pkg::PDATA_W-1:0] pwdata       = '0;
    logic [spc_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    stack_permutation_checker_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_coach      (i_coach),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_achievable (o_achievable),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    // Coaches waiting to be sent, and verdicts waiting to come back.
    logic [spc_pkg::COACH_W-1:0] pending_coaches[$];
    bit                          verdicts_due[$];
    int unsigned                 mismatches = 0;
    bit                          idling_enabled = 1'b1;

    // Predicted state of the station.
    logic [spc_pkg::COACH_W-1:0] length_reg;
    logic [spc_pkg::COACH_W-1:0] siding [STACK_DEPTH];
    int unsigned                 siding_depth;
    int unsigned                 next_arrival;
    int unsigned                 coaches_seen;
    bit                          train_broken;

    function automatic void clear_train();
        siding_depth = 0;
        next_arrival = 1;
        coaches_seen = 0;
        train_broken = 1'b0;
    endfunction

    function automatic int unsigned effective_length();
        if (length_reg == 0)
            return 1;
        if (length_reg > STACK_DEPTH)
            return STACK_DEPTH;
        return length_reg;
    endfunction

    function automatic void apply_register(input logic [spc_pkg::PADDR_W-1:0] addr,
                                           input logic [spc_pkg::PDATA_W-1:0] value);
        if (addr[2] == spc_pkg::REG_TRAIN_LENGTH) begin
            length_reg = value[spc_pkg::COACH_W-1:0];
            clear_train();
        end
    endfunction

    // Returns 1 when the coach completes a train; the verdict then holds the result.
    function automatic bit advance_train(input logic [spc_pkg::COACH_W-1:0] wanted,
                                         output bit verdict);
        int unsigned len;
        len = effective_length();
        verdict = 1'b0;
        if (!train_broken) begin
            if (wanted == 0 || wanted > len) begin
                train_broken = 1'b1;
            end else begin
                while (next_arrival <= wanted && siding_depth < STACK_DEPTH) begin
                    siding[siding_depth] = next_arrival[spc_pkg::COACH_W-1:0];
                    siding_depth++;
                    next_arrival++;
                end
                if (siding_depth > 0 && siding[siding_depth-1] == wanted)
                    siding_depth--;
                else
                    train_broken = 1'b1;
            end
        end
        coaches_seen++;
        if (coaches_seen >= len) begin
            verdict = !train_broken;
            clear_train();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Item driver.
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (pending_coaches.size() > 0) begin
                i_in_valid <= 1'b1;
                i_coach    <= pending_coaches.pop_front();
                if (idling_enabled && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 17);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver stalls.
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (idling_enabled && $urandom_range(0, 11) == 0)
                stall_left <= $urandom_range(1, 17);
        end
    end

    // Prediction on every accepted item transfer.
    always @(posedge i_clk) begin : item_monitor
        bit verdict;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (advance_train(i_coach, verdict))
                verdicts_due.push_back(verdict);
        end
    end

    // Check every accepted result transfer against the oldest verdict due.
    always @(posedge i_clk) begin : result_monitor
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("result transfer with no verdict outstanding");
            end else begin
                want = verdicts_due.pop_front();
                if (o_achievable !== want)
                    report_mismatch($sformatf("achievable %b, predicted %b",
                                              o_achievable, want));
            end
        end
    end

    // Waits until the sender is empty and every verdict has come, then lets
    // the block finish any pushes still under way for a train in progress.
    task automatic wait_idle();
        while (pending_coaches.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (effective_length() + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [spc_pkg::PADDR_W-1:0] addr,
                             input int unsigned value);
        logic [spc_pkg::PDATA_W-1:0] data;
        data = $urandom();
        data[spc_pkg::COACH_W-1:0] = value[spc_pkg::COACH_W-1:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(addr, data);
    endtask

    // Queues the first `keep` coaches of one train of `len` coaches. A
    // well-formed order comes from a random walk over the stack; the other
    // flavors break it by a swap, an out-of-range coach, or plain noise.
    task automatic queue_train(input int unsigned len, input int unsigned keep);
        logic [spc_pkg::COACH_W-1:0] order[$];
        logic [spc_pkg::COACH_W-1:0] held[$];
        logic [spc_pkg::COACH_W-1:0] tmp;
        int unsigned                 next_in;
        int unsigned                 pick;
        int unsigned                 a;
        int unsigned                 b;
        next_in = 1;
        while (order.size() < len) begin
            if (next_in <= len && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
                held.push_back(next_in[spc_pkg::COACH_W-1:0]);
                next_in++;
            end else begin
                order.push_back(held.pop_back());
            end
        end
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 75 && len >= 2) begin
            a = $urandom_range(0, len - 1);
            b = $urandom_range(0, len - 1);
            tmp = order[a];
            order[a] = order[b];
            order[b] = tmp;
        end else if (pick >= 75 && pick < 85) begin
            a = $urandom_range(0, len - 1);
            order[a] = ($urandom_range(0, 2) == 0)
                     ? '0 : spc_pkg::COACH_W'($urandom_range(len + 1, 2047));
        end else if (pick >= 85) begin
            foreach (order[i])
                order[i] = ($urandom_range(0, 3) == 0)
                         ? spc_pkg::COACH_W'($urandom_range(0, 2047))
                         : spc_pkg::COACH_W'($urandom_range(1, len));
        end
        for (int i = 0; i < keep; i++)
            pending_coaches.push_back(order[i]);
    endtask

    initial begin : stimulus
        int unsigned random_coaches;
        int unsigned len_val;
        int unsigned eff;
        int unsigned r;
        length_reg = 1;
        clear_train();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset length of one: every coach ends a train.
        pending_coaches.push_back(11'd1);
        pending_coaches.push_back(11'd0);
        pending_coaches.push_back(11'd2047);
        wait_idle();

        // Three coaches: an order that buries the wanted coach, a reversal,
        // a zero coach followed by coaches after the train is already lost,
        // and a coach above the length.
        write_reg(TRAIN_LENGTH_ADDR, 3);
        pending_coaches.push_back(11'd3); pending_coaches.push_back(11'd1);
        pending_coaches.push_back(11'd2);
        pending_coaches.push_back(11'd3); pending_coaches.push_back(11'd2);
        pending_coaches.push_back(11'd1);
        pending_coaches.push_back(11'd2); pending_coaches.push_back(11'd0);
        pending_coaches.push_back(11'd1);
        pending_coaches.push_back(11'd1); pending_coaches.push_back(11'd4);
        pending_coaches.push_back(11'd3);
        wait_idle();

        // A length of zero acts as one.
        write_reg(TRAIN_LENGTH_ADDR, 0);
        pending_coaches.push_back(11'd1);
        wait_idle();

        // A length write in the middle of a train starts a fresh one.
        write_reg(TRAIN_LENGTH_ADDR, 3);
        pending_coaches.push_back(11'd1); pending_coaches.push_back(11'd2);
        wait_idle();
        write_reg(TRAIN_LENGTH_ADDR, 2);
        pending_coaches.push_back(11'd2); pending_coaches.push_back(11'd1);
        wait_idle();

        // A write to an unmapped address leaves the length alone.
        write_reg(SPARE_ADDR, 5);
        pending_coaches.push_back(11'd1); pending_coaches.push_back(11'd2);
        pending_coaches.push_back(11'd1); pending_coaches.push_back(11'd1);
        wait_idle();

        random_coaches = 0;
        while (random_coaches < RANDOM_COACHES) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                len_val = $urandom_range(1, 8);
            else if (r < 9)
                len_val = $urandom_range(9, 64);
            else
                len_val = 0;
            eff = (len_val == 0) ? 1 : len_val;
            wait_idle();
            write_reg(TRAIN_LENGTH_ADDR, len_val);
            // The tail of the run goes without any idling on either side.
            if (random_coaches + QUIET_COACHES >= RANDOM_COACHES)
                idling_enabled = 1'b0;
            else
                idling_enabled = ($urandom_range(0, 4) != 0);
            repeat ((eff <= 8) ? $urandom_range(2, 8) : $urandom_range(1, 2)) begin
                queue_train(eff, eff);
                random_coaches += eff;
            end
            // Sometimes leave a train unfinished; the next length write drops it.
            if (eff >= 2 && $urandom_range(0, 5) == 0) begin
                r = $urandom_range(1, eff - 1);
                queue_train(eff, r);
                random_coaches += r;
            end
        end
        wait_idle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/stack_permutation_checker_top.sv
bench/tb_top.sv
